### design/bounded_deque_with_search_defines.svh
// Assertion shorthands used by the checker file.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

    localparam int unsigned BDQ_DEPTH  = 16;
    localparam int unsigned BDQ_DATA_W = 32;
    localparam int unsigned BDQ_CNT_W  = $clog2(BDQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_DUMP       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

`default_nettype wire

### design/bdq_if.sv
`default_nettype none

// Command channel: one beat per operation.
interface bdq_req_if
    import bdq_pkg::*;
();
    logic                          valid;
    logic                          ready;
    op_t                           op;
    logic signed [BDQ_DATA_W-1:0]  item_value;

    modport source (output valid, output op, output item_value, input ready);
    modport sink   (input valid, input op, input item_value, output ready);
endinterface

// Result channel: one or more beats per operation, last marks the final one.
interface bdq_rsp_if
    import bdq_pkg::*;
#(
    parameter int unsigned CNT_W = BDQ_CNT_W
) ();
    logic                          valid;
    logic                          ready;
    status_t                       status;
    logic signed [BDQ_DATA_W-1:0]  out_value;
    logic                          last;
    logic [CNT_W-1:0]              occupancy;

    modport source (output valid, output status, output out_value, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_value, input last,
                    input occupancy, output ready);
endinterface

`default_nettype wire

### design/bdq_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module bdq_ram
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH  = BDQ_DEPTH,
    parameter int unsigned ADDR_W = $clog2(DEPTH),
    parameter int unsigned DATA_W = BDQ_DATA_W
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/bounded_deque_with_search.sv
// Push and pop: the result is in the output register in the cycle after the beat is accepted.
// Search: walks the N held entries with one RAM read per cycle, stopping at a hit.
// Dump: one entry beat per cycle for the N entries while the sink does not stall.
// A new command is taken only when the walk unit is idle and the output slot is free.
// Reset (rst_n low, async) empties the deque: front and count go to zero.
// The entry RAM is not cleared; only entries inside the held range are ever read.
`default_nettype none

module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = BDQ_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // IDLE takes commands, WALK streams RAM reads, DONE posts the search verdict.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Ring position base + off, both below DEPTH, so one subtract wraps it.
    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Control state
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;   // reads issued in this walk
    logic [CNT_W-1:0]        cons_reg,  cons_next;    // read results consumed
    logic                    dv_reg,    dv_next;      // RAM read data is pending
    logic                    dump_reg,  dump_next;
    status_t                 verdict_reg, verdict_next;
    logic [BDQ_DATA_W-1:0]   key_reg,   key_next;

    // Output register
    logic                    ovalid_reg, ovalid_next;
    status_t                 ostatus_reg, ostatus_next;
    logic [BDQ_DATA_W-1:0]   ovalue_reg, ovalue_next;
    logic                    olast_reg,  olast_next;
    logic [CNT_W-1:0]        oocc_reg,   oocc_next;

    // RAM port
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [BDQ_DATA_W-1:0]   rd_data;

    logic out_free;
    logic accept;
    logic is_empty;
    logic is_full;
    logic consume;
    logic last_entry;
    logic hit;

    bdq_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (BDQ_DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !ovalid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = req.valid && req.ready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == FULL_CNT);

    // Walk datapath: one entry pending at most, dump waits on the output slot
    assign consume    = dv_reg && (!dump_reg || out_free);
    assign last_entry = ((cons_reg + CNT_W'(1)) == count_reg);
    assign hit        = (rd_data == key_reg);
    assign rd_addr    = ring_add(front_reg, issue_reg[IDX_W-1:0]);
    assign rd_en      = (state_reg == S_WALK) && (issue_reg != count_reg)
                        && (!dv_reg || consume);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        cons_next    = cons_reg;
        dv_next      = dv_reg;
        dump_next    = dump_reg;
        verdict_next = verdict_reg;
        key_next     = key_reg;

        ovalid_next  = ovalid_reg && !rsp.ready;
        ostatus_next = ostatus_reg;
        ovalue_next  = ovalue_reg;
        olast_next   = olast_reg;
        oocc_next    = oocc_reg;

        wr_en   = 1'b0;
        wr_addr = ring_add(front_reg, count_reg[IDX_W-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default single-beat result; pushes/pops fix status and count
                    ovalid_next  = 1'b1;
                    ostatus_next = ST_OK;
                    ovalue_next  = '0;
                    olast_next   = 1'b1;
                    oocc_next    = count_reg;
                    case (req.op)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                ostatus_next = ST_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? LAST_IDX
                                                               : front_reg - 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                count_next = count_reg + 1'b1;
                                oocc_next  = count_next;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                ostatus_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                oocc_next  = count_next;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                ostatus_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_add(front_reg, IDX_W'(1));
                                count_next = count_reg - 1'b1;
                                oocc_next  = count_next;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                ostatus_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                oocc_next  = count_next;
                            end
                        end
                        OP_SEARCH, OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                ostatus_next = ST_EMPTY;
                            end
                            else
                            begin
                                // Result beats come from the walk instead
                                ovalid_next = 1'b0;
                                state_next  = S_WALK;
                                issue_next  = '0;
                                cons_next   = '0;
                                dv_next     = 1'b0;
                                dump_next   = (req.op == OP_DUMP);
                                key_next    = req.item_value;
                            end
                        end
                        default:
                        begin
                            // unused op codes: plain ok beat
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                    dv_next    = 1'b1;
                end
                else if (consume)
                begin
                    dv_next = 1'b0;
                end

                if (consume)
                begin
                    cons_next = cons_reg + 1'b1;
                    if (dump_reg)
                    begin
                        ovalid_next  = 1'b1;
                        ostatus_next = ST_OK;
                        ovalue_next  = rd_data;
                        olast_next   = last_entry;
                        oocc_next    = count_reg;
                        if (last_entry)
                        begin
                            state_next = S_IDLE;
                            dv_next    = 1'b0;
                        end
                    end
                    else if (hit || last_entry)
                    begin
                        verdict_next = hit ? ST_OK : ST_NOT_FOUND;
                        state_next   = S_DONE;
                        dv_next      = 1'b0;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = verdict_reg;
                    ovalue_next  = '0;
                    olast_next   = 1'b1;
                    oocc_next    = count_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            issue_reg  <= '0;
            cons_reg   <= '0;
            dv_reg     <= 1'b0;
            dump_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            cons_reg   <= cons_next;
            dv_reg     <= dv_next;
            dump_reg   <= dump_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        key_reg     <= key_next;
        ostatus_reg <= ostatus_next;
        ovalue_reg  <= ovalue_next;
        olast_reg   <= olast_next;
        oocc_reg    <= oocc_next;
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = ostatus_reg;
    assign rsp.out_value = ovalue_reg;
    assign rsp.last      = olast_reg;
    assign rsp.occupancy = oocc_reg;

endmodule

`default_nettype wire

### design/bdq_checker.sv
`include "bounded_deque_with_search_defines.svh"
`default_nettype none

module bdq_checker
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = BDQ_DEPTH,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [1:0]       out_status,
    input wire logic             out_last,
    input wire logic [CNT_W-1:0] out_occupancy
);

    `BDQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, out_valid, out_occupancy <= CNT_W'(DEPTH), "occupancy above depth")
    `BDQ_ASSERT_IMPL(a_empty_beat, clk, rst_n, out_valid && (out_status == ST_EMPTY), (out_occupancy == '0) && out_last, "empty status on a filled deque")
    `BDQ_ASSERT_IMPL(a_full_beat, clk, rst_n, out_valid && (out_status == ST_FULL), (out_occupancy == CNT_W'(DEPTH)) && out_last, "full status below depth")
    `BDQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_last), "stalled result beat changed")

endmodule

bind bounded_deque_with_search bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_status    (rsp.status),
    .out_last      (rsp.last),
    .out_occupancy (rsp.occupancy)
);

`default_nettype wire

### tb/bounded_deque_with_search_tb.sv
`timescale 1ns / 1ps

// Bounded deque with linear search: directed corner cases, a back-pressure
// fill to capacity, then biased random traffic under three idle patterns.
module bounded_deque_with_search_tb
    import bdq_pkg::*;
();

    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat on either side
    localparam int unsigned HOLD_CYCLES = 160;   // long receiver hold-off
    localparam int unsigned RANDOM_PER_PHASE = 140;

    typedef struct {
        status_t                      status;
        logic signed [BDQ_DATA_W-1:0] value;
        logic                         last;
        logic [BDQ_CNT_W-1:0]         occupancy;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the deque: ring, front pointer, entry count.
    logic signed [BDQ_DATA_W-1:0] shadow_ring [BDQ_DEPTH];
    int unsigned                  shadow_front;
    int unsigned                  shadow_count;

    // Result beats predicted but not yet seen, oldest first.
    result_beat_t expected_beats [$];

    // Idle percentages for each side, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Hold-off requests: the test bumps hold_asks, the ready process serves it.
    int unsigned hold_asks;
    int unsigned hold_served;
    int unsigned hold_left;

    int unsigned errors;
    int unsigned mismatches_shown;
    int unsigned beats_checked;
    int unsigned commands_sent;
    int unsigned refused_pushes;
    int unsigned empty_reports;
    int unsigned search_hits;
    int unsigned search_misses;
    int unsigned dumps_seen;
    int unsigned odd_opcodes;
    int unsigned max_fill_seen;
    int unsigned stall_cycles;

    //------------------------------------------------------------------
    // Predictor: applies one accepted command to the shadow deque and
    // queues the beats it must produce.
    //------------------------------------------------------------------
    function automatic void push_beat(status_t st, logic signed [BDQ_DATA_W-1:0] v,
                                      logic lst);
        result_beat_t b;
        b.status    = st;
        b.value     = v;
        b.last      = lst;
        b.occupancy = BDQ_CNT_W'(shadow_count);
        expected_beats.push_back(b);
    endfunction

    function automatic void predict_command(op_t op, logic signed [BDQ_DATA_W-1:0] v);
        status_t     st;
        logic        hit;
        int unsigned i;
        st  = ST_OK;
        hit = 1'b0;
        commands_sent++;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count >= BDQ_DEPTH)
                begin
                    st = ST_FULL;
                    refused_pushes++;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    shadow_front = (shadow_front + BDQ_DEPTH - 1) % BDQ_DEPTH;
                    shadow_ring[shadow_front] = v;
                    shadow_count++;
                end
                else
                begin
                    shadow_ring[(shadow_front + shadow_count) % BDQ_DEPTH] = v;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    st = ST_EMPTY;
                    empty_reports++;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                        shadow_front = (shadow_front + 1) % BDQ_DEPTH;
                    shadow_count--;
                end
            end
            OP_SEARCH:
            begin
                if (shadow_count == 0)
                begin
                    st = ST_EMPTY;
                    empty_reports++;
                end
                else
                begin
                    for (i = 0; i < shadow_count; i++)
                        if (shadow_ring[(shadow_front + i) % BDQ_DEPTH] === v)
                            hit = 1'b1;
                    st = hit ? ST_OK : ST_NOT_FOUND;
                    if (hit)
                        search_hits++;
                    else
                        search_misses++;
                end
            end
            OP_DUMP:
            begin
                dumps_seen++;
                if (shadow_count == 0)
                begin
                    empty_reports++;
                    push_beat(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < shadow_count; i++)
                        push_beat(ST_OK, shadow_ring[(shadow_front + i) % BDQ_DEPTH],
                                  i + 1 == shadow_count);
                end
                return;
            end
            default:
                odd_opcodes++;  // undefined codes: no state change, one plain beat
        endcase
        if (shadow_count > max_fill_seen)
            max_fill_seen = shadow_count;
        push_beat(st, '0, 1'b1);
    endfunction

    //------------------------------------------------------------------
    // Command sender. Called at a rising edge; returns in the time step
    // of the edge that accepted the beat. Valid stays high into the next
    // call unless that call decides to idle first.
    //------------------------------------------------------------------
    task automatic send_command(input op_t op, input logic signed [BDQ_DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.item_value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_command(op, v);
    endtask

    // Mix of extremes, small values (to get duplicates) and full-range words.
    function automatic logic signed [BDQ_DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return '0;
            4, 5:    return BDQ_DATA_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result channel: ready pattern plus the long hold-off.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_asks != hold_served)
        begin
            hold_served  <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void note_mismatch(string what);
        errors++;
        if (mismatches_shown < 10)
        begin
            mismatches_shown++;
            $display("[%0t] MISMATCH %s", $realtime, what);
        end
    endfunction

    // Every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_beat_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
                note_mismatch($sformatf(
                    "unexpected beat: status=%0d value=%0d last=%b occ=%0d",
                    rsp_ch.status, rsp_ch.out_value, rsp_ch.last, rsp_ch.occupancy));
            else
            begin
                want = expected_beats.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.out_value !== want.value
                    || rsp_ch.last !== want.last || rsp_ch.occupancy !== want.occupancy)
                    note_mismatch($sformatf(
                        {"exp status=%0d value=%0d last=%b occ=%0d, ",
                         "got status=%0d value=%0d last=%b occ=%0d"},
                        want.status, want.value, want.last, want.occupancy,
                        rsp_ch.status, rsp_ch.out_value, rsp_ch.last, rsp_ch.occupancy));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d beats outstanding",
                     $realtime, stall_cycles, expected_beats.size());
            $display("bounded_deque_with_search_tb: errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Pops, search and dump on an empty deque, plus the two undefined codes.
    task automatic test_empty_list();
        send_command(OP_POP_FRONT, 32'sh7FFF_FFFF);
        send_command(OP_POP_BACK, 32'sh8000_0000);
        send_command(OP_SEARCH, '0);
        send_command(OP_DUMP, -32'sd1);
        send_command(op_t'(3'd6), 32'sh5555_5555);
        send_command(op_t'(3'd7), 32'shAAAA_AAAA);
    endtask

    // Extreme values pushed at both ends, searches that hit the two inner entries or miss.
    task automatic test_ends_and_search();
        send_command(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_command(OP_PUSH_FRONT, 32'sh8000_0000);
        send_command(OP_PUSH_BACK, '0);
        send_command(OP_PUSH_FRONT, -32'sd1);
        send_command(OP_SEARCH, 32'sh8000_0000);
        send_command(OP_SEARCH, 32'sh7FFF_FFFF);
        send_command(OP_SEARCH, 32'sd1);            // one bit off a held zero
        send_command(OP_DUMP, '0);
        send_command(OP_POP_FRONT, '0);
        send_command(OP_POP_BACK, '0);
        send_command(op_t'(3'd6), '0);              // undefined code with entries held
    endtask

    // Receiver holds off while pushes keep coming: the block backs up,
    // the deque reaches capacity and the extra pushes are refused.
    task automatic test_fill_under_backpressure();
        int unsigned k;
        hold_asks <= hold_asks + 1;
        for (k = 0; k < BDQ_DEPTH + 6; k++)
            send_command(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        send_command(OP_DUMP, '0);
        send_command(OP_SEARCH, shadow_ring[(shadow_front + BDQ_DEPTH - 1) % BDQ_DEPTH]);
        send_command(OP_SEARCH, $urandom);
        while (shadow_count != 0)
            send_command($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        send_command(OP_DUMP, '0);
    endtask

    // Biased random traffic. A fill/drain mode sweeps the occupancy over its
    // whole range; searches mostly look for a held value.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned k;
        int unsigned r;
        bit          filling;
        op_t         op;
        logic signed [BDQ_DATA_W-1:0] v;
        filling = 1'b1;
        for (k = 0; k < n_items; k++)
        begin
            if (shadow_count >= BDQ_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (shadow_count == 0)
                filling = 1'b1;
            else if ($urandom_range(39) == 0)
                filling = !filling;
            r = $urandom_range(99);
            v = pick_word();
            if (r < 2)
                op = op_t'($urandom_range(7, 6));
            else if (r < 10)
                op = OP_DUMP;
            else if (r < 30)
            begin
                op = OP_SEARCH;
                if (shadow_count != 0 && $urandom_range(99) < 60)
                    v = shadow_ring[(shadow_front + $urandom_range(shadow_count - 1))
                                    % BDQ_DEPTH];
            end
            else if (r < (filling ? 82 : 48))
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
            send_command(op, v);
        end
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_PUSH_FRONT;
        req_ch.item_value <= '0;
        shadow_front      = 0;
        shadow_count      = 0;
        hold_asks         = 0;
        send_idle_pct     = 28;
        recv_idle_pct     = 47;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_ends_and_search();
        test_fill_under_backpressure();

        test_random_traffic(RANDOM_PER_PHASE);
        send_idle_pct = 47;
        recv_idle_pct = 28;
        test_random_traffic(RANDOM_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_PER_PHASE);

        req_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        // let a stray extra beat show up, if there is one
        repeat (BDQ_DEPTH + 8) @(posedge clk);
        errors += expected_beats.size();

        $display("covered %0d commands, %0d result beats; peak fill %0d, %0d refused pushes,",
                 commands_sent, beats_checked, max_fill_seen, refused_pushes);
        $display("%0d empty reports, %0d search hits, %0d misses, %0d dumps, %0d undefined codes",
                 empty_reports, search_hits, search_misses, dumps_seen, odd_opcodes);
        if (errors == 0)
            $display("bounded_deque_with_search_tb: clean");
        else
            $display("bounded_deque_with_search_tb: errors");
        $finish;
    end

endmodule
